>>> rtl/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg: shared constants for the barometric compensation pipeline
// Register map indexes, datapath widths, formula constants and the output
// saturation limits.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_SENS_COEFF    = 3'd0;
  localparam logic [2:0] REG_OFFSET_COEFF  = 3'd1;
  localparam logic [2:0] REG_SENS_TEMPCO   = 3'd2;
  localparam logic [2:0] REG_OFFSET_TEMPCO = 3'd3;
  localparam logic [2:0] REG_REF_TEMP      = 3'd4;
  localparam logic [2:0] REG_TEMP_SLOPE    = 3'd5;

  // field widths
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 15;
  localparam int PRESS_W = 17;
  localparam int PADDR_W = 5;

  // internal widths: temperature, offset/sensitivity
  localparam int TW = 20;
  localparam int OW = 42;

  // formula constants, hundredths of a degree
  localparam int T_BASE = 2000;
  localparam int T_XLOW = -1500;

  // saturation limits
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRESS_MIN = 1000;
  localparam int PRESS_MAX = 120000;

  // clock edges from an accepted transfer to its result strobe
  localparam int LATENCY = 10;

endpackage

>>> rtl/baro_pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top: second-order barometric compensation
// Ten-stage pipeline that turns a raw pressure/temperature conversion pair
// and six calibration words into temperature and pressure in hundredths.
// ----------------------------------------------------------------------------
// One conversion pair is accepted on every clock cycle in which start is high;
// busy is held low, since the pipeline never stalls. Each accepted pair gives
// exactly one result, shown for a single cycle with out_valid high after it has
// passed every stage; results leave in the order the pairs came in. The
// receiver cannot hold results off, so it must take every strobe. The work
// is spread over ten register stages: the 25 by 17 bit coefficient products,
// the squares for the low-temperature corrections, the pressure product split
// into two partial products, and the final subtract and saturation.
// Calibration registers sit on the APB port at byte addresses 0 to 20 and must
// only be written while no transfer is in flight.
module baro_pressure_temp_compensation_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [bptc_pkg::RAW_W-1:0]    in_raw_pressure,
  input  logic [bptc_pkg::RAW_W-1:0]    in_raw_temp,
  // result channel
  output logic                          out_valid,
  output logic signed [bptc_pkg::TEMP_W-1:0] out_temp_centi,
  output logic [bptc_pkg::PRESS_W-1:0]  out_press_centi,
  output logic                          out_clipped,
  output logic                          out_calib_valid,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bptc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bptc_pkg::*;

  // --------------------------------------------------------------------------
  // calibration registers
  logic [CAL_W-1:0] sens_coeff_r, offset_coeff_r, sens_tempco_r;
  logic [CAL_W-1:0] offset_tempco_r, ref_temp_r, temp_slope_r;
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // write the addressed word, drop writes beyond the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_coeff_r    <= '0;
      offset_coeff_r  <= '0;
      sens_tempco_r   <= '0;
      offset_tempco_r <= '0;
      ref_temp_r      <= '0;
      temp_slope_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SENS_COEFF:    sens_coeff_r    <= pwdata[CAL_W-1:0];
        REG_OFFSET_COEFF:  offset_coeff_r  <= pwdata[CAL_W-1:0];
        REG_SENS_TEMPCO:   sens_tempco_r   <= pwdata[CAL_W-1:0];
        REG_OFFSET_TEMPCO: offset_tempco_r <= pwdata[CAL_W-1:0];
        REG_REF_TEMP:      ref_temp_r      <= pwdata[CAL_W-1:0];
        REG_TEMP_SLOPE:    temp_slope_r    <= pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // read back the addressed word
  always_comb begin
    unique case (reg_idx)
      REG_SENS_COEFF:    prdata = {16'd0, sens_coeff_r};
      REG_OFFSET_COEFF:  prdata = {16'd0, offset_coeff_r};
      REG_SENS_TEMPCO:   prdata = {16'd0, sens_tempco_r};
      REG_OFFSET_TEMPCO: prdata = {16'd0, offset_tempco_r};
      REG_REF_TEMP:      prdata = {16'd0, ref_temp_r};
      REG_TEMP_SLOPE:    prdata = {16'd0, temp_slope_r};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control
  logic       accept;
  logic [8:0] vld_r;
  logic       out_valid_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[7:0], accept};
      out_valid_r <= vld_r[8];
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // stage 1: temperature difference
  logic signed [24:0]      dt_nxt, dt1_r;
  logic [RAW_W-1:0]        d1_r1;

  assign dt_nxt = $signed({1'b0, in_raw_temp}) - $signed({1'b0, ref_temp_r, 8'd0});

  // stage 2: coefficient products and dT squared
  logic signed [41:0]      pt_nxt, po_nxt, ps_nxt, pt2_r, po2_r, ps2_r;
  logic signed [49:0]      pdd_nxt, pdd2_r;
  logic [RAW_W-1:0]        d1_r2;

  assign pt_nxt  = dt1_r * $signed({1'b0, temp_slope_r});
  assign po_nxt  = dt1_r * $signed({1'b0, offset_tempco_r});
  assign ps_nxt  = dt1_r * $signed({1'b0, sens_tempco_r});
  assign pdd_nxt = dt1_r * dt1_r;

  // stage 3: first-order temperature, offset and sensitivity
  logic signed [TW-1:0]    t3_nxt, t3_r;
  logic signed [OW-1:0]    off3_nxt, sens3_nxt, off3_r, sens3_r;
  logic [17:0]             t2_3_r;
  logic [RAW_W-1:0]        d1_r3;

  assign t3_nxt    = TW'(pt2_r >>> 23) + TW'(T_BASE);
  assign off3_nxt  = $signed({10'd0, offset_coeff_r, 16'd0}) + (po2_r >>> 7);
  assign sens3_nxt = $signed({11'd0, sens_coeff_r, 15'd0}) + (ps2_r >>> 8);

  // stage 4: squares for the low-temperature terms
  logic signed [TW-1:0]    tu, tv, t4_r;
  logic signed [39:0]      a_nxt, b_nxt, a4_r, b4_r;
  logic                    lt_base_nxt, lt_xlow_nxt, lt_base4_r, lt_xlow4_r;
  logic signed [OW-1:0]    off4_r, sens4_r;
  logic [17:0]             t2_4_r;
  logic [RAW_W-1:0]        d1_r4;

  assign tu          = t3_r - TW'(T_BASE);
  assign tv          = t3_r - TW'(T_XLOW);
  assign a_nxt       = tu * tu;
  assign b_nxt       = tv * tv;
  assign lt_base_nxt = t3_r < TW'(T_BASE);
  assign lt_xlow_nxt = t3_r < TW'(T_XLOW);

  // stage 5: second-order offset and sensitivity terms
  logic signed [OW-1:0]    a42, b42, a5, b7, b11;
  logic signed [OW-1:0]    off2_nxt, sens2_nxt, off2_5_r, sens2_5_r;
  logic signed [TW-1:0]    t5_r;
  logic                    lt_base5_r;
  logic signed [OW-1:0]    off5_r, sens5_r;
  logic [17:0]             t2_5_r;
  logic [RAW_W-1:0]        d1_r5;

  assign a42 = OW'(a4_r);
  assign b42 = OW'(b4_r);
  assign a5  = (a42 <<< 2) + a42;
  assign b7  = (b42 <<< 3) - b42;
  assign b11 = (b42 <<< 3) + (b42 <<< 1) + b42;

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (lt_base4_r) begin
      off2_nxt  = a5 >>> 1;
      sens2_nxt = a5 >>> 2;
      if (lt_xlow4_r) begin
        off2_nxt  = (a5 >>> 1) + b7;
        sens2_nxt = (a5 >>> 2) + (b11 >>> 1);
      end
    end
  end

  // stage 6: apply the corrections
  logic signed [TW-1:0]    t6_nxt, t6_r;
  logic signed [OW-1:0]    off6_nxt, sens6_nxt, off6_r, sens6_r;
  logic [RAW_W-1:0]        d1_r6;

  assign t6_nxt    = lt_base5_r ? (t5_r - $signed({2'b00, t2_5_r})) : t5_r;
  assign off6_nxt  = off5_r - off2_5_r;
  assign sens6_nxt = sens5_r - sens2_5_r;

  // stage 7: pressure partial products, temperature saturation
  logic [44:0]             pp_lo_nxt, pp_lo_r;
  logic signed [45:0]      pp_hi_nxt, pp_hi_r;
  logic signed [TW-1:0]    tc_nxt, tc7_r;
  logic                    tclip_nxt, tclip7_r;
  logic signed [OW-1:0]    off7_r;

  assign pp_lo_nxt = 45'(d1_r6) * 45'(sens6_r[20:0]);
  assign pp_hi_nxt = $signed({1'b0, d1_r6}) * $signed(sens6_r[41:21]);

  always_comb begin
    tc_nxt    = t6_r;
    tclip_nxt = 1'b0;
    if (t6_r < TW'(TEMP_MIN)) begin
      tc_nxt    = TW'(TEMP_MIN);
      tclip_nxt = 1'b1;
    end else if (t6_r > TW'(TEMP_MAX)) begin
      tc_nxt    = TW'(TEMP_MAX);
      tclip_nxt = 1'b1;
    end
  end

  // stage 8: product shifted down by 21
  logic signed [46:0]      q_nxt, q8_r;
  logic signed [TW-1:0]    tc8_r;
  logic                    tclip8_r;
  logic signed [OW-1:0]    off8_r;

  assign q_nxt = 47'(pp_hi_r) + $signed({23'd0, pp_lo_r[44:21]});

  // stage 9: subtract offset, shift down by 15
  logic signed [46:0]      pd;
  logic signed [32:0]      p_nxt, p9_r;
  logic signed [TW-1:0]    tc9_r;
  logic                    tclip9_r;

  assign pd    = q8_r - 47'(off8_r);
  assign p_nxt = 33'(pd >>> 15);

  // stage 10: pressure saturation and flags
  logic [PRESS_W-1:0]          pc_nxt, out_press_r;
  logic                        pclip_nxt;
  logic signed [TEMP_W-1:0]    out_temp_r;
  logic                        out_clip_r, out_calv_r, calv_nxt;

  always_comb begin
    pc_nxt    = p9_r[PRESS_W-1:0];
    pclip_nxt = 1'b0;
    if (p9_r < 33'(PRESS_MIN)) begin
      pc_nxt    = PRESS_W'(PRESS_MIN);
      pclip_nxt = 1'b1;
    end else if (p9_r > 33'(PRESS_MAX)) begin
      pc_nxt    = PRESS_W'(PRESS_MAX);
      pclip_nxt = 1'b1;
    end
  end

  assign calv_nxt = (|sens_coeff_r) && (|offset_coeff_r) && (|sens_tempco_r) &&
                    (|offset_tempco_r) && (|ref_temp_r) && (|temp_slope_r);

  // hold payload in the stage registers; no reset needed
  always_ff @(posedge clk) begin
    dt1_r      <= dt_nxt;
    d1_r1      <= in_raw_pressure;
    pt2_r      <= pt_nxt;
    po2_r      <= po_nxt;
    ps2_r      <= ps_nxt;
    pdd2_r     <= pdd_nxt;
    d1_r2      <= d1_r1;
    t3_r       <= t3_nxt;
    off3_r     <= off3_nxt;
    sens3_r    <= sens3_nxt;
    t2_3_r     <= pdd2_r[48:31];
    d1_r3      <= d1_r2;
    t4_r       <= t3_r;
    a4_r       <= a_nxt;
    b4_r       <= b_nxt;
    lt_base4_r <= lt_base_nxt;
    lt_xlow4_r <= lt_xlow_nxt;
    off4_r     <= off3_r;
    sens4_r    <= sens3_r;
    t2_4_r     <= t2_3_r;
    d1_r4      <= d1_r3;
    off2_5_r   <= off2_nxt;
    sens2_5_r  <= sens2_nxt;
    t5_r       <= t4_r;
    lt_base5_r <= lt_base4_r;
    off5_r     <= off4_r;
    sens5_r    <= sens4_r;
    t2_5_r     <= t2_4_r;
    d1_r5      <= d1_r4;
    t6_r       <= t6_nxt;
    off6_r     <= off6_nxt;
    sens6_r    <= sens6_nxt;
    d1_r6      <= d1_r5;
    pp_lo_r    <= pp_lo_nxt;
    pp_hi_r    <= pp_hi_nxt;
    tc7_r      <= tc_nxt;
    tclip7_r   <= tclip_nxt;
    off7_r     <= off6_r;
    q8_r       <= q_nxt;
    tc8_r      <= tc7_r;
    tclip8_r   <= tclip7_r;
    off8_r     <= off7_r;
    p9_r       <= p_nxt;
    tc9_r      <= tc8_r;
    tclip9_r   <= tclip8_r;
    out_press_r <= pc_nxt;
    out_temp_r  <= tc9_r[TEMP_W-1:0];
    out_clip_r  <= tclip9_r || pclip_nxt;
    out_calv_r  <= calv_nxt;
  end

  assign out_temp_centi  = out_temp_r;
  assign out_press_centi = out_press_r;
  assign out_clipped     = out_clip_r;
  assign out_calib_valid = out_calv_r;

endmodule

>>> rtl/bptc_checker.sv
// ----------------------------------------------------------------------------
// bptc_checker: port-level checks for the compensation pipeline
// Fixed latency in both directions and saturation ranges of the results.
// ----------------------------------------------------------------------------
module bptc_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              out_valid,
  input  logic signed [bptc_pkg::TEMP_W-1:0] out_temp_centi,
  input  logic [bptc_pkg::PRESS_W-1:0]      out_press_centi
);
  import bptc_pkg::*;

  // every accepted transfer gives a result after the pipeline latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted transfer produced no result");

  // no result without an accepted transfer at the matching edge
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without an accepted transfer");

  // temperature stays inside its saturation range
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temp_centi >= TEMP_W'(TEMP_MIN)) &&
                  (out_temp_centi <= TEMP_W'(TEMP_MAX)))
    else $error("temperature outside its range");

  // pressure stays inside its saturation range
  a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_press_centi >= PRESS_W'(PRESS_MIN)) &&
                  (out_press_centi <= PRESS_W'(PRESS_MAX)))
    else $error("pressure outside its range");

endmodule

bind baro_pressure_temp_compensation_top bptc_checker u_bptc_checker (.*);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for baro_pressure_temp_compensation_top
// Loads calibration words over the APB port, streams raw conversion pairs
// with random gaps and checks each result strobe against a local
// second-order compensation calculation.
// ----------------------------------------------------------------------------
module testbench;
  import bptc_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RAW_MAX     = 16777215;
  localparam logic [2:0]  REG_SPARE_A = 3'd6;
  localparam logic [2:0]  REG_SPARE_B = 3'd7;

  // gap styles for a batch of conversion pairs
  localparam int GAPS_NONE   = 0;
  localparam int GAPS_FULL   = 1;
  localparam int GAPS_SPARSE = 2;

  typedef struct {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temp;
    int unsigned      gap;
    bit               drain;
  } conv_pair_t;

  typedef struct {
    logic signed [TEMP_W-1:0] temp_centi;
    logic [PRESS_W-1:0]       press_centi;
    logic                     clipped;
    logic                     calib_valid;
  } reading_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [RAW_W-1:0]           in_raw_pressure = '0;
  logic [RAW_W-1:0]           in_raw_temp = '0;
  logic                       out_valid;
  logic signed [TEMP_W-1:0]   out_temp_centi;
  logic [PRESS_W-1:0]         out_press_centi;
  logic                       out_clipped;
  logic                       out_calib_valid;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  conv_pair_t   pending_pairs_q[$];
  reading_t     expected_readings_q[$];
  logic [15:0]  cal_shadow [8];
  logic [15:0]  typical_cal [6] = '{16'd40127, 16'd36924, 16'd23317,
                                    16'd23282, 16'd33464, 16'd28312};
  logic [2:0]   cal_regs [6] = '{REG_SENS_COEFF, REG_OFFSET_COEFF, REG_SENS_TEMPCO,
                                 REG_OFFSET_TEMPCO, REG_REF_TEMP, REG_TEMP_SLOPE};
  int unsigned  gap_waited = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  cycle_cnt = 0;
  reading_t     got_reading;
  reading_t     want_reading;

  baro_pressure_temp_compensation_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_raw_pressure (in_raw_pressure),
    .in_raw_temp     (in_raw_temp),
    .out_valid       (out_valid),
    .out_temp_centi  (out_temp_centi),
    .out_press_centi (out_press_centi),
    .out_clipped     (out_clipped),
    .out_calib_valid (out_calib_valid),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Second-order compensation of one conversion pair under the shadow
  // calibration; 64-bit signed throughout, shifts round toward minus infinity
  function automatic reading_t compensate_reading(input logic [RAW_W-1:0] raw_p,
                                                  input logic [RAW_W-1:0] raw_t);
    longint   d1, d2, c1, c2, c3, c4, c5, c6;
    longint   dt, t, off, sens, p, a, b, t2, off2, sens2;
    bit       clip;
    reading_t r;
    d1 = longint'({40'd0, raw_p});
    d2 = longint'({40'd0, raw_t});
    c1 = longint'({48'd0, cal_shadow[REG_SENS_COEFF]});
    c2 = longint'({48'd0, cal_shadow[REG_OFFSET_COEFF]});
    c3 = longint'({48'd0, cal_shadow[REG_SENS_TEMPCO]});
    c4 = longint'({48'd0, cal_shadow[REG_OFFSET_TEMPCO]});
    c5 = longint'({48'd0, cal_shadow[REG_REF_TEMP]});
    c6 = longint'({48'd0, cal_shadow[REG_TEMP_SLOPE]});
    clip = 1'b0;

    dt   = d2 - c5 * 256;
    t    = T_BASE + ((dt * c6) >>> 23);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);

    // low-temperature corrections; the very-cold test uses T before T2
    if (t < T_BASE) begin
      a     = (t - T_BASE) * (t - T_BASE);
      t2    = (dt * dt) >>> 31;
      off2  = (5 * a) >>> 1;
      sens2 = (5 * a) >>> 2;
      if (t < T_XLOW) begin
        b     = (t - T_XLOW) * (t - T_XLOW);
        off2  = off2 + 7 * b;
        sens2 = sens2 + ((11 * b) >>> 1);
      end
      t    = t - t2;
      off  = off - off2;
      sens = sens - sens2;
    end

    p = (((d1 * sens) >>> 21) - off) >>> 15;

    // saturate both readings
    if (t < TEMP_MIN) begin t = TEMP_MIN; clip = 1'b1; end
    if (t > TEMP_MAX) begin t = TEMP_MAX; clip = 1'b1; end
    if (p < PRESS_MIN) begin p = PRESS_MIN; clip = 1'b1; end
    if (p > PRESS_MAX) begin p = PRESS_MAX; clip = 1'b1; end

    r.temp_centi  = t[TEMP_W-1:0];
    r.press_centi = p[PRESS_W-1:0];
    r.clipped     = clip;
    r.calib_valid = (c1 != 0) && (c2 != 0) && (c3 != 0) &&
                    (c4 != 0) && (c5 != 0) && (c6 != 0);
    return r;
  endfunction

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("tb: failure");
      $finish;
    end
  end

  // Driver: present the head pair after its gap, hold it until the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      gap_waited = 0;
    end else begin
      if (start && !busy) begin
        expected_readings_q.push_back(compensate_reading(in_raw_pressure, in_raw_temp));
        void'(pending_pairs_q.pop_front());
        gap_waited = 0;
      end
      if (start && busy) begin
        // hold the current pair
      end else if (pending_pairs_q.size() != 0 &&
                   gap_waited >= pending_pairs_q[0].gap &&
                   !(pending_pairs_q[0].drain && expected_readings_q.size() != 0)) begin
        start           <= 1'b1;
        in_raw_pressure <= pending_pairs_q[0].raw_pressure;
        in_raw_temp     <= pending_pairs_q[0].raw_temp;
      end else begin
        start <= 1'b0;
        if (pending_pairs_q.size() != 0)
          gap_waited = gap_waited + 1;
      end
    end
  end

  // Monitor: take every result strobe and compare with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_reading.temp_centi  = out_temp_centi;
      got_reading.press_centi = out_press_centi;
      got_reading.clipped     = out_clipped;
      got_reading.calib_valid = out_calib_valid;
      if (expected_readings_q.size() == 0) begin
        $display("%0t: result with nothing expected, temp %0d press %0d",
                 $time, got_reading.temp_centi, got_reading.press_centi);
        mismatch_cnt++;
      end else begin
        want_reading = expected_readings_q.pop_front();
        if (got_reading.temp_centi !== want_reading.temp_centi) begin
          $display("%0t: temp_centi expected %0d got %0d",
                   $time, want_reading.temp_centi, got_reading.temp_centi);
          mismatch_cnt++;
        end
        if (got_reading.press_centi !== want_reading.press_centi) begin
          $display("%0t: press_centi expected %0d got %0d",
                   $time, want_reading.press_centi, got_reading.press_centi);
          mismatch_cnt++;
        end
        if (got_reading.clipped !== want_reading.clipped) begin
          $display("%0t: clipped expected %0b got %0b",
                   $time, want_reading.clipped, got_reading.clipped);
          mismatch_cnt++;
        end
        if (got_reading.calib_valid !== want_reading.calib_valid) begin
          $display("%0t: calib_valid expected %0b got %0b",
                   $time, want_reading.calib_valid, got_reading.calib_valid);
          mismatch_cnt++;
        end
      end
    end
  end

  // APB write: setup cycle, then access cycle; upper data bits are noise
  task automatic cal_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= REG_TEMP_SLOPE)
      cal_shadow[idx] = val;
  endtask

  // Load a full set of words, optionally with a write to an unmapped address
  task automatic load_calibration(input logic [15:0] words [6], input bit spare);
    for (int i = 0; i < 6; i++)
      cal_write(cal_regs[i], words[i]);
    if (spare)
      cal_write(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
  endtask

  // Block until nothing is queued or in flight
  task automatic wait_idle();
    while (pending_pairs_q.size() != 0 || expected_readings_q.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic queue_pair(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t,
                            input int unsigned gap, input bit drain);
    conv_pair_t c;
    c.raw_pressure = raw_p;
    c.raw_temp     = raw_t;
    c.gap          = gap;
    c.drain        = drain;
    pending_pairs_q.push_back(c);
  endtask

  function automatic int unsigned draw_gap(input int style);
    if (style == GAPS_NONE)
      return 0;
    if (style == GAPS_SPARSE && $urandom_range(0, 9) != 0)
      return 0;
    return $urandom_range(0, 19);
  endfunction

  // Random pairs: temperature mostly close to the reference so the
  // second-order branches are exercised, with some fully random noise
  task automatic queue_random_pairs(input int count, input int style);
    longint      centre, offs, v;
    int          sh;
    logic [23:0] raw_p;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 6)
        raw_p = 24'($urandom);
      else
        raw_p = 24'(32'h0080_0000 + $urandom_range(0, 32'h0020_0000));
      if ($urandom_range(0, 3) == 0) begin
        v = longint'($urandom_range(0, RAW_MAX));
      end else begin
        case ($urandom_range(0, 4))
          0: sh = 8;
          1: sh = 14;
          2: sh = 18;
          3: sh = 21;
          default: sh = 23;
        endcase
        centre = longint'({48'd0, cal_shadow[REG_REF_TEMP]}) * 256;
        offs   = longint'($urandom_range(0, (1 << sh) - 1)) - (longint'(1) << (sh - 1));
        v      = centre + offs;
        if (v < 0) v = 0;
        if (v > RAW_MAX) v = RAW_MAX;
      end
      queue_pair(raw_p, v[23:0], draw_gap(style), $urandom_range(0, 99) == 0);
    end
  endtask

  function automatic logic [15:0] draw_word(input int i);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return typical_cal[i] + 16'($urandom_range(0, 8191)) - 16'd4096;
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [15:0] words [6];
    for (int i = 0; i < 8; i++)
      cal_shadow[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: all words zero, calib_valid low
    queue_pair(24'd0, 24'd0, 0, 1'b0);
    queue_pair(24'hFFFFFF, 24'hFFFFFF, 0, 1'b0);
    queue_pair(24'd9085466, 24'd8569150, 3, 1'b0);
    wait_idle();

    // Typical calibration, directed corners
    load_calibration(typical_cal, 1'b0);
    queue_pair(24'd9085466, 24'd8569150, 0, 1'b0);   // room temperature
    queue_pair(24'd9085466, 24'd8566784, 0, 1'b0);   // dT zero, exactly 20 C
    queue_pair(24'd9085466, 24'd8566783, 0, 1'b0);   // just below 20 C
    queue_pair(24'd9085466, 24'd7529764, 0, 1'b0);   // around -15 C edge
    queue_pair(24'd9085466, 24'd7529763, 0, 1'b0);
    queue_pair(24'd9085466, 24'd7000000, 2, 1'b0);   // very cold, extra term
    queue_pair(24'd0, 24'd0, 0, 1'b0);               // temperature clips low, pressure clips high
    queue_pair(24'hFFFFFF, 24'hFFFFFF, 0, 1'b0);     // both clip high
    queue_pair(24'd0, 24'hFFFFFF, 0, 1'b0);
    queue_pair(24'hFFFFFF, 24'd0, 0, 1'b1);          // wait for drain first
    queue_pair(24'd4000000, 24'd8000000, 5, 1'b0);
    queue_pair(24'd12000000, 24'd9000000, 0, 1'b0);
    queue_pair(24'hAAAAAA, 24'h555555, 0, 1'b0);
    queue_pair(24'h555555, 24'hAAAAAA, 19, 1'b0);
    wait_idle();

    // Extremes of calibration: all ones, with a write to a spare address
    for (int i = 0; i < 6; i++) words[i] = 16'hFFFF;
    load_calibration(words, 1'b1);
    queue_pair(24'd0, 24'd0, 0, 1'b0);
    queue_pair(24'hFFFFFF, 24'hFFFFFF, 0, 1'b0);
    queue_random_pairs(100, GAPS_FULL);
    wait_idle();

    // Smallest nonzero words
    for (int i = 0; i < 6; i++) words[i] = 16'h0001;
    load_calibration(words, 1'b0);
    queue_random_pairs(100, GAPS_NONE);
    wait_idle();

    // One zero word among typical ones
    words = typical_cal;
    words[$urandom_range(0, 5)] = 16'h0000;
    load_calibration(words, 1'b1);
    queue_random_pairs(100, GAPS_SPARSE);
    wait_idle();

    // Random calibrations
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < 6; i++) words[i] = draw_word(i);
      load_calibration(words, $urandom_range(0, 2) == 0);
      queue_random_pairs(140, ph % 3);
      wait_idle();
    end

    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/bptc_pkg.sv
rtl/baro_pressure_temp_compensation_top.sv
rtl/bptc_checker.sv
tb/sv/testbench.sv
